// ----- hw/rtl/disk_contact_frame_kinematics_defines.svh -----
// Assertion macros for the disk contact frame block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DISK_CONTACT_FRAME_KINEMATICS_DEFINES_SVH
`define DISK_CONTACT_FRAME_KINEMATICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define DCFK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DCFK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCFK_ASSERT_IMP(lbl, ante, cons, msg)
`define DCFK_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/dcfk_pkg.sv -----
package dcfk_pkg;

    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 31;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x_a;
        logic signed [31:0] pos_y_a;
        logic [30:0]        radius_a;
        logic signed [31:0] pos_x_b;
        logic signed [31:0] pos_y_b;
        logic [30:0]        radius_b;
        logic signed [31:0] vel_x_a;
        logic signed [31:0] vel_y_a;
        logic signed [31:0] spin_a;
        logic signed [31:0] vel_x_b;
        logic signed [31:0] vel_y_b;
        logic signed [31:0] spin_b;
    } t_item;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] gap;
        logic               active;
        logic               touching;
        logic               degenerate;
        logic signed [31:0] rel_vel_normal;
        logic signed [31:0] rel_vel_tangent;
        logic signed [31:0] rel_spin;
    } t_result;

    // classified pair as handed from front to back
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic [30:0]        ra;
        logic [30:0]        rb;
        logic signed [31:0] xa;
        logic signed [31:0] ya;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic [64:0]        sq;
    } t_job;

    // one step of the digit-by-digit square root
    typedef struct packed {
        t_job        job;
        logic [65:0] rad;
        logic [35:0] rem;
        logic [32:0] root;
    } t_root;

    // one step of the two long divisions
    typedef struct packed {
        t_job        job;
        logic [32:0] len;
        logic [32:0] mx;
        logic [32:0] my;
        logic [33:0] remx;
        logic [33:0] remy;
        logic [30:0] qx;
        logic [30:0] qy;
    } t_div;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [32:0]        len;
        logic [30:0]        ra;
        logic [30:0]        rb;
        logic signed [31:0] xa;
        logic signed [31:0] ya;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic signed [63:0] pcx;
        logic signed [63:0] pcy;
        logic signed [64:0] pn1;
        logic signed [64:0] pn2;
        logic signed [64:0] pt1;
        logic signed [64:0] pt2;
        logic signed [63:0] pw1;
        logic signed [63:0] pw2;
    } t_mul;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [34:0] gap;
        logic               active;
        logic               touching;
        logic               degen;
        logic signed [35:0] vn;
        logic signed [35:0] vt;
        logic signed [48:0] rim;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
    } t_sum;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sh7fff_ffff;
        lo = -68'sh8000_0000;
        if (v > hi) return 32'sh7fff_ffff;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_root sqrt_step(input t_root s);
        t_root       r;
        logic [35:0] rn;
        logic [35:0] trial;
        r     = s;
        rn    = {s.rem[33:0], s.rad[65:64]};
        trial = {1'b0, s.root, 2'b01};
        if (rn >= trial) begin
            r.rem  = rn - trial;
            r.root = {s.root[31:0], 1'b1};
        end else begin
            r.rem  = rn;
            r.root = {s.root[31:0], 1'b0};
        end
        r.rad = {s.rad[63:0], 2'b00};
        return r;
    endfunction

    // returns {quotient bit, new remainder}
    function automatic logic [34:0] div_bit(input logic [33:0] t, input logic [32:0] len);
        if (t >= {1'b0, len}) return {1'b1, t - {1'b0, len}};
        return {1'b0, t};
    endfunction

endpackage

// ----- hw/rtl/dcfk_front.sv -----
module dcfk_front
    import dcfk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_item i_item,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_job  o_q_job
);

    logic  adv;
    logic  r_v1, r_v2;
    t_item r_item;
    t_job  r_job;
    t_job  n_job;
    logic [32:0] mx, my;
    logic [65:0] sqx, sqy;

    // both stages move together unless the queue is full and the second stage holds a pair
    assign adv      = !i_q_full || !r_v2;
    assign full     = !adv;
    assign o_q_push = r_v2 && !i_q_full;
    assign o_q_job  = r_job;

    // differences and squared distance
    always_comb begin
        n_job     = '0;
        n_job.dx  = 33'($signed(r_item.pos_x_a)) - 33'($signed(r_item.pos_x_b));
        n_job.dy  = 33'($signed(r_item.pos_y_a)) - 33'($signed(r_item.pos_y_b));
        n_job.dvx = 33'($signed(r_item.vel_x_a)) - 33'($signed(r_item.vel_x_b));
        n_job.dvy = 33'($signed(r_item.vel_y_a)) - 33'($signed(r_item.vel_y_b));
        n_job.ra  = r_item.radius_a;
        n_job.rb  = r_item.radius_b;
        n_job.xa  = r_item.pos_x_a;
        n_job.ya  = r_item.pos_y_a;
        n_job.wa  = r_item.spin_a;
        n_job.wb  = r_item.spin_b;
        mx        = mag33(n_job.dx);
        my        = mag33(n_job.dy);
        sqx       = {33'd0, mx} * {33'd0, mx};
        sqy       = {33'd0, my} * {33'd0, my};
        n_job.sq  = sqx[64:0] + sqy[64:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item <= i_item;
            r_job  <= n_job;
        end
    end

endmodule

// ----- hw/rtl/dcfk_queue.sv -----
module dcfk_queue
    import dcfk_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

// ----- hw/rtl/dcfk_back.sv -----
module dcfk_back
    import dcfk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [30:0] i_act,
    input  logic        i_q_empty,
    input  t_job        i_q_head,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result
);

    logic    adv;
    logic    r_vs [SQRT_STEPS];
    logic    r_vd [DIV_STEPS];
    t_root   r_sq [SQRT_STEPS];
    t_div    r_dv [DIV_STEPS];
    logic    r_vm, r_vu, r_ovalid;
    t_mul    r_mul, n_mul;
    t_sum    r_sum, n_sum;
    t_result r_out, n_out;
    t_root   sq_init;

    // whole back pipeline moves when the result slot frees up
    assign adv     = !r_ovalid || pop;
    assign o_q_pop = adv && !i_q_empty;
    assign empty   = !r_ovalid;
    assign o_result = r_out;

    always_comb begin
        sq_init      = '0;
        sq_init.job  = i_q_head;
        sq_init.rad  = {1'b0, i_q_head.sq};
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vs[k] <= 1'b0;
            else if (adv) r_vs[k] <= (k == 0) ? !i_q_empty : r_vs[(k == 0) ? 0 : k-1];
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_sq[k] <= sqrt_step((k == 0) ? sq_init : r_sq[(k == 0) ? 0 : k-1]);
        end
    end

    // two divisions |d| * 2^30 / len, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_div        src;
        t_div        nxt;
        logic [33:0] tx, ty;
        logic [34:0] bx, by;
        always_comb begin
            if (k == 0) begin
                src      = '0;
                src.job  = r_sq[SQRT_STEPS-1].job;
                src.len  = r_sq[SQRT_STEPS-1].root;
                src.mx   = mag33(r_sq[SQRT_STEPS-1].job.dx);
                src.my   = mag33(r_sq[SQRT_STEPS-1].job.dy);
                tx       = {1'b0, src.mx};
                ty       = {1'b0, src.my};
            end else begin
                src      = r_dv[(k == 0) ? 0 : k-1];
                tx       = {src.remx[32:0], 1'b0};
                ty       = {src.remy[32:0], 1'b0};
            end
            bx       = div_bit(tx, src.len);
            by       = div_bit(ty, src.len);
            nxt      = src;
            nxt.remx = bx[33:0];
            nxt.remy = by[33:0];
            nxt.qx   = {src.qx[29:0], bx[34]};
            nxt.qy   = {src.qy[29:0], by[34]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vd[k] <= 1'b0;
            else if (adv) r_vd[k] <= (k == 0) ? r_vs[SQRT_STEPS-1] : r_vd[(k == 0) ? 0 : k-1];
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_dv[k] <= nxt;
        end
    end

    // signed normal and all products
    always_comb begin
        t_div        d;
        logic [30:0] qx, qy;
        logic        dg;
        d         = r_dv[DIV_STEPS-1];
        dg        = (d.len == '0);
        qx        = (d.qx > ONE_Q30) ? ONE_Q30 : d.qx;
        qy        = (d.qy > ONE_Q30) ? ONE_Q30 : d.qy;
        n_mul     = '0;
        n_mul.nx  = dg ? 32'sd0 : (d.job.dx[32] ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
        n_mul.ny  = dg ? 32'sd0 : (d.job.dy[32] ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
        n_mul.len = d.len;
        n_mul.ra  = d.job.ra;
        n_mul.rb  = d.job.rb;
        n_mul.xa  = d.job.xa;
        n_mul.ya  = d.job.ya;
        n_mul.wa  = d.job.wa;
        n_mul.wb  = d.job.wb;
        n_mul.pcx = $signed({1'b0, d.job.ra}) * n_mul.nx;
        n_mul.pcy = $signed({1'b0, d.job.ra}) * n_mul.ny;
        n_mul.pn1 = d.job.dvx * n_mul.nx;
        n_mul.pn2 = d.job.dvy * n_mul.ny;
        n_mul.pt1 = d.job.dvy * n_mul.nx;
        n_mul.pt2 = d.job.dvx * n_mul.ny;
        n_mul.pw1 = $signed({1'b0, d.job.ra}) * d.job.wa;
        n_mul.pw2 = $signed({1'b0, d.job.rb}) * d.job.wb;
    end

    // sums, floor shifts and compares
    always_comb begin
        logic signed [65:0] sn, st;
        logic signed [64:0] sw;
        logic [31:0]        rsum;
        logic [33:0]        thr;
        sn         = 66'(r_mul.pn1) + 66'(r_mul.pn2);
        st         = 66'(r_mul.pt1) - 66'(r_mul.pt2);
        sw         = 65'(r_mul.pw1) + 65'(r_mul.pw2);
        rsum       = 32'(r_mul.ra) + 32'(r_mul.rb);
        thr        = 34'(rsum) + 34'(i_act);
        n_sum.nx       = r_mul.nx;
        n_sum.ny       = r_mul.ny;
        n_sum.cx       = 34'(r_mul.xa) - 34'(r_mul.pcx >>> 30);
        n_sum.cy       = 34'(r_mul.ya) - 34'(r_mul.pcy >>> 30);
        n_sum.gap      = $signed({2'b00, r_mul.len}) - $signed({3'b000, rsum});
        n_sum.active   = (34'(r_mul.len) < thr);
        n_sum.touching = (r_mul.len < 33'(rsum));
        n_sum.degen    = (r_mul.len == '0);
        n_sum.vn       = 36'(sn >>> 30);
        n_sum.vt       = 36'(st >>> 30);
        n_sum.rim      = 49'(sw >>> 16);
        n_sum.wa       = r_mul.wa;
        n_sum.wb       = r_mul.wb;
    end

    // saturation into the result slot
    always_comb begin
        n_out.normal_x        = r_sum.nx;
        n_out.normal_y        = r_sum.ny;
        n_out.contact_x       = sat32(68'(r_sum.cx));
        n_out.contact_y       = sat32(68'(r_sum.cy));
        n_out.gap             = sat32(68'(r_sum.gap));
        n_out.active          = r_sum.active;
        n_out.touching        = r_sum.touching;
        n_out.degenerate      = r_sum.degen;
        n_out.rel_vel_normal  = sat32(68'(r_sum.vn));
        n_out.rel_vel_tangent = sat32(68'(r_sum.vt) - 68'(r_sum.rim));
        n_out.rel_spin        = sat32(68'(r_sum.wa) - 68'(r_sum.wb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm     <= 1'b0;
            r_vu     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_vm     <= r_vd[DIV_STEPS-1];
            r_vu     <= r_vm;
            r_ovalid <= r_vu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mul <= n_mul;
            r_sum <= n_sum;
            r_out <= n_out;
        end
    end

endmodule

// ----- hw/rtl/disk_contact_frame_kinematics.sv -----
// Channel   Dir  Handshake                     Beat
// item      in   push / full                   t_item, one disk pair
// result    out  pop / empty                   t_result, contact frame
// config    in   i_cfg_valid / o_cfg_ready     act_distance, unsigned Q15.16
//
// One pair per cycle sustained while results are popped, through two front
// stages, the queue, 33 root stages, 31 divide stages, products, sums.
// Reset clears all valid flags and act_distance. A stalled result holds the
// back pipeline; the front keeps filling the queue until it is full.
`include "disk_contact_frame_kinematics_defines.svh"
module disk_contact_frame_kinematics
    import dcfk_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_item       i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    logic        q_push, q_full, q_pop, q_empty;
    t_job        q_in, q_head;
    logic [30:0] r_act;

    // activation margin register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_act <= '0;
        else if (i_cfg_valid) r_act <= i_cfg_data;
    end

    dcfk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in)
    );

    dcfk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    dcfk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_act     (r_act),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

    `DCFK_ASSERT_IMP(a_degen_zero, !empty && o_result.degenerate, o_result.normal_x == 32'sd0 && o_result.normal_y == 32'sd0, "degenerate pair with nonzero normal")
    `DCFK_ASSERT_IMP(a_touch_active, !empty && o_result.touching, o_result.active, "touching pair not flagged active")
    `DCFK_ASSERT_NXT(a_queue_push, q_push && q_full, 1'b0, "push into full queue")

endmodule
